### hdl/stiq_pkg.sv
// ----------------------------------------------------------------------------
// stiq_pkg
// Types, codes and time arithmetic shared by the sorted interval timer queue.
// ----------------------------------------------------------------------------
package stiq_pkg;

   // default queue depth and fixed field widths
   localparam int SLOTS_DEF  = 16;
   localparam int ID_BITS    = 16;
   localparam int OWNER_BITS = 8;
   localparam int MAX_FIRE   = 16;
   localparam int FIRE_W     = $clog2(MAX_FIRE + 1);

   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
   localparam logic [19:0] US_MAX       = 20'd999999;
   localparam logic [30:0] MAXSEC_RST   = 31'd100000000;
   localparam logic [19:0] RES_RST      = 20'd1000;

   // operation kinds
   localparam logic [2:0] KIND_SET   = 3'd0;
   localparam logic [2:0] KIND_GET   = 3'd1;
   localparam logic [2:0] KIND_DEL   = 3'd2;
   localparam logic [2:0] KIND_PURGE = 3'd3;
   localparam logic [2:0] KIND_TICK  = 3'd4;

   // result status
   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_INVAL  = 2'd1;
   localparam logic [1:0] STS_NOTFND = 2'd2;
   localparam logic [1:0] STS_FULL   = 2'd3;

   // register indexes
   localparam logic CSR_MAX_SECONDS = 1'b0;
   localparam logic CSR_RESOLUTION  = 1'b1;

   // datapath operations
   localparam logic [3:0] OP_NOP         = 4'd0;
   localparam logic [3:0] OP_EMIT        = 4'd1;
   localparam logic [3:0] OP_SET_REPLACE = 4'd2;
   localparam logic [3:0] OP_SET_ALLOC   = 4'd3;
   localparam logic [3:0] OP_INSERT_ACK  = 4'd4;
   localparam logic [3:0] OP_INSERT      = 4'd5;
   localparam logic [3:0] OP_FIND        = 4'd6;
   localparam logic [3:0] OP_REPORT      = 4'd7;
   localparam logic [3:0] OP_REPORT_DEL  = 4'd8;
   localparam logic [3:0] OP_PURGE_START = 4'd9;
   localparam logic [3:0] OP_PURGE_STEP  = 4'd10;
   localparam logic [3:0] OP_REMOVE_RD   = 4'd11;
   localparam logic [3:0] OP_TICK_NOW    = 4'd12;
   localparam logic [3:0] OP_FIRE        = 4'd13;
   localparam logic [3:0] OP_RELOAD      = 4'd14;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         owner;
      logic [15:0]        lookup_id;
      logic [30:0]        time_sec;
      logic [19:0]        time_us;
      logic [30:0]        period_sec;
      logic [19:0]        period_us;
      logic signed [31:0] event_req;
      logic signed [31:0] code;
      logic signed [31:0] subcode;
      logic [19:0]        elapsed_us;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        result_id;
      logic [7:0]         result_owner;
      logic [30:0]        remain_sec;
      logic [19:0]        remain_us;
      logic [30:0]        interval_sec;
      logic [19:0]        interval_us;
      logic signed [31:0] fired_event;
      logic signed [31:0] fired_code;
      logic signed [31:0] fired_subcode;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] sec;
      logic [19:0] us;
   } time_type;

   typedef struct packed {
      logic [30:0] sec;
      logic [19:0] us;
   } rem_type;

   typedef struct packed {
      logic [OWNER_BITS-1:0] owner;
      logic [ID_BITS-1:0]    id;
      time_type              expiry;
      logic [30:0]           rel_sec;
      logic [19:0]           rel_us;
      logic signed [31:0]    ev;
      logic signed [31:0]    cd;
      logic signed [31:0]    sc;
   } entry_type;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] sts;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic              set_bad;
      logic              hit;
      logic              full;
      logic              purge_end;
      logic              purge_hit;
      logic              periodic;
      logic              out_free;
      logic [FIRE_W-1:0] expired_cnt;
   } stat_type;

   // a strictly after b
   function automatic logic later(time_type a, time_type b);
      return (a.sec > b.sec) || ((a.sec == b.sec) && (a.us > b.us));
   endfunction

   // now plus a relative time, seconds saturate
   function automatic time_type abs_time(time_type now_t, logic [31:0] rs, logic [19:0] ru);
      logic [20:0] us;
      logic [1:0]  c;
      logic [33:0] s;
      time_type    r;
      us = {1'b0, now_t.us} + {1'b0, ru};
      if (us >= 21'd2000000) begin
         us = us - 21'd2000000;
         c  = 2'd2;
      end else if (us >= {1'b0, USEC_PER_SEC}) begin
         us = us - {1'b0, USEC_PER_SEC};
         c  = 2'd1;
      end else begin
         c = 2'd0;
      end
      s = {2'b00, now_t.sec} + {2'b00, rs} + {32'd0, c};
      if (s > 34'h0FFFFFFFF) begin
         r.sec = 32'hFFFFFFFF;
         r.us  = US_MAX;
      end else begin
         r.sec = s[31:0];
         r.us  = us[19:0];
      end
      return r;
   endfunction

   // time left before expiry, zero when already due
   function automatic rem_type remaining(time_type e, time_type now_t);
      logic [32:0] s;
      logic [20:0] us;
      rem_type     r;
      r = '0;
      if (later(e, now_t)) begin
         s = {1'b0, e.sec} - {1'b0, now_t.sec};
         if (e.us >= now_t.us) begin
            us = {1'b0, e.us} - {1'b0, now_t.us};
         end else begin
            us = {1'b0, e.us} + {1'b0, USEC_PER_SEC} - {1'b0, now_t.us};
            s  = s - 33'd1;
         end
         r.sec = (s > 33'h07FFFFFFF) ? 31'h7FFFFFFF : s[30:0];
         r.us  = us[19:0];
      end
      return r;
   endfunction

endpackage

### hdl/stiq_datapath.sv
// ----------------------------------------------------------------------------
// stiq_datapath
// Sorted slot array, clock, id counter, registers and the result register.
// ----------------------------------------------------------------------------
module stiq_datapath
   import stiq_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_accept,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int FIRE_SPAN = (SLOTS < MAX_FIRE) ? SLOTS : MAX_FIRE;

   entry_type          slot_ff [SLOTS];
   entry_type          slot_in [SLOTS];
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   entry_type          new_ff, new_in;
   req_type            req_ff;
   time_type           now_ff, now_in;
   logic [ID_BITS-1:0] next_id_ff, next_id_in;
   logic [30:0]        max_sec_ff;
   logic [19:0]        res_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [SLOTS-1:0]   match;
   logic [SLOTS-1:0]   later_v;
   logic [SLOTS-1:0]   rm_ge;
   logic [IDX_W-1:0]   match_idx;
   logic [FIRE_W-1:0]  exp_cnt;
   entry_type          rd_e;
   logic [19:0]        res_eff;
   logic [19:0]        tu_fix, pu_fix;
   logic               bad_t, bad_p;
   logic [ID_BITS-1:0] alloc_id;
   logic               removing, inserting, out_free;

   assign rd_e     = slot_ff[rd_idx_ff[IDX_W-1:0]];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // argument checks and round-up of short times
   always_comb begin
      res_eff = (res_ff > US_MAX) ? US_MAX : res_ff;
      bad_t   = (req_ff.time_sec > max_sec_ff) || (req_ff.time_us >= USEC_PER_SEC);
      bad_p   = (req_ff.period_sec > max_sec_ff) || (req_ff.period_us >= USEC_PER_SEC);
      tu_fix  = req_ff.time_us;
      pu_fix  = req_ff.period_us;
      if (req_ff.time_sec == 31'd0 && req_ff.time_us != 20'd0 && req_ff.time_us < res_eff) begin
         tu_fix = res_eff;
      end
      if (req_ff.period_sec == 31'd0 && req_ff.period_us != 20'd0 &&
          req_ff.period_us < res_eff) begin
         pu_fix = res_eff;
      end
   end

   // per-slot compares
   always_comb begin
      match_idx = '0;
      exp_cnt   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match[i]   = (CNT_W'(i) < n_ff) && (slot_ff[i].owner == req_ff.owner) &&
                      (slot_ff[i].id == req_ff.lookup_id);
         later_v[i] = (CNT_W'(i) < n_ff) && later(slot_ff[i].expiry, new_ff.expiry);
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_idx = IDX_W'(i);
         end
      end
      for (int i = 0; i < FIRE_SPAN; i++) begin
         if ((CNT_W'(i) < n_ff) && !later(slot_ff[i].expiry, now_ff)) begin
            exp_cnt = exp_cnt + FIRE_W'(1);
         end
      end
   end

   // removal span
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         case (cmd.op)
            OP_SET_REPLACE: rm_ge[i] = (IDX_W'(i) >= match_idx);
            OP_REMOVE_RD,
            OP_REPORT_DEL:  rm_ge[i] = (CNT_W'(i) >= rd_idx_ff);
            OP_FIRE:        rm_ge[i] = 1'b1;
            default:        rm_ge[i] = 1'b0;
         endcase
      end
   end

   assign removing  = (cmd.op == OP_SET_REPLACE) || (cmd.op == OP_REMOVE_RD) ||
                      (cmd.op == OP_REPORT_DEL) || (cmd.op == OP_FIRE);
   assign inserting = (cmd.op == OP_INSERT) || (cmd.op == OP_INSERT_ACK);

   // id allocation skips zero
   assign alloc_id = (next_id_ff == '0) ? ID_BITS'(1) : next_id_ff;

   // slot array shifting
   always_comb begin
      n_in = n_ff;
      for (int i = 0; i < SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (removing) begin
         n_in = n_ff - CNT_W'(1);
         for (int i = 0; i < SLOTS - 1; i++) begin
            if (rm_ge[i]) begin
               slot_in[i] = slot_ff[i+1];
            end
         end
      end else if (inserting) begin
         n_in = n_ff + CNT_W'(1);
         for (int i = 0; i < SLOTS; i++) begin
            if (later_v[i] || (CNT_W'(i) == n_ff)) begin
               slot_in[i] = new_ff;
            end
         end
         for (int i = 1; i < SLOTS; i++) begin
            if (later_v[i-1]) begin
               slot_in[i] = slot_ff[i-1];
            end
         end
      end
   end

   // new entry, clock, read index, id counter
   always_comb begin
      new_in     = new_ff;
      now_in     = now_ff;
      rd_idx_in  = rd_idx_ff;
      next_id_in = next_id_ff;
      case (cmd.op)
         OP_SET_REPLACE,
         OP_SET_ALLOC: begin
            new_in.owner   = req_ff.owner;
            new_in.id      = (cmd.op == OP_SET_ALLOC) ? alloc_id : req_ff.lookup_id;
            new_in.expiry  = abs_time(now_ff, {1'b0, req_ff.time_sec}, tu_fix);
            new_in.rel_sec = req_ff.period_sec;
            new_in.rel_us  = pu_fix;
            new_in.ev      = req_ff.event_req;
            new_in.cd      = req_ff.code;
            new_in.sc      = req_ff.subcode;
            if (cmd.op == OP_SET_ALLOC) begin
               next_id_in = alloc_id + ID_BITS'(1);
            end
         end
         OP_FIND:        rd_idx_in = CNT_W'(match_idx);
         OP_PURGE_START: rd_idx_in = '0;
         OP_PURGE_STEP:  rd_idx_in = rd_idx_ff + CNT_W'(1);
         OP_TICK_NOW:    now_in = abs_time(now_ff, 32'd0, req_ff.elapsed_us);
         OP_FIRE:        new_in = slot_ff[0];
         OP_RELOAD:      new_in.expiry = abs_time(now_ff, {1'b0, new_ff.rel_sec}, new_ff.rel_us);
         default: ;
      endcase
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         OP_EMIT: begin
            rsp_in        = '0;
            rsp_in.status = cmd.sts;
            rsp_in.last   = 1'b1;
            rsp_valid_in  = 1'b1;
         end
         OP_INSERT_ACK: begin
            rsp_in           = '0;
            rsp_in.status    = STS_OK;
            rsp_in.result_id = new_ff.id;
            rsp_in.last      = 1'b1;
            rsp_valid_in     = 1'b1;
         end
         OP_REPORT,
         OP_REPORT_DEL: begin
            rsp_in              = '0;
            rsp_in.status       = STS_OK;
            {rsp_in.remain_sec, rsp_in.remain_us} = remaining(rd_e.expiry, now_ff);
            rsp_in.interval_sec = rd_e.rel_sec;
            rsp_in.interval_us  = rd_e.rel_us;
            rsp_in.last         = 1'b1;
            rsp_valid_in        = 1'b1;
         end
         OP_FIRE: begin
            rsp_in               = '0;
            rsp_in.status        = STS_OK;
            rsp_in.result_id     = slot_ff[0].id;
            rsp_in.result_owner  = slot_ff[0].owner;
            rsp_in.fired_event   = slot_ff[0].ev;
            rsp_in.fired_code    = slot_ff[0].cd;
            rsp_in.fired_subcode = slot_ff[0].sc;
            rsp_in.last          = cmd.last;
            rsp_valid_in         = 1'b1;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         rd_idx_ff    <= '0;
         now_ff       <= '0;
         next_id_ff   <= '0;
         max_sec_ff   <= MAXSEC_RST;
         res_ff       <= RES_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         rd_idx_ff    <= rd_idx_in;
         now_ff       <= now_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_MAX_SECONDS) begin
            max_sec_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_RESOLUTION) begin
            res_ff <= csr_wdata[19:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
      new_ff <= new_in;
      rsp_ff <= rsp_in;
      if (req_accept) begin
         req_ff <= req_data;
      end
   end

   // status to the controller
   always_comb begin
      stat.kind        = req_ff.kind;
      stat.set_bad     = bad_t || bad_p;
      stat.hit         = |match;
      stat.full        = (n_ff == CNT_W'(SLOTS));
      stat.purge_end   = (rd_idx_ff >= n_ff);
      stat.purge_hit   = (rd_e.owner == req_ff.owner);
      stat.periodic    = (new_ff.rel_sec != 31'd0) || (new_ff.rel_us != 20'd0);
      stat.out_free    = out_free;
      stat.expired_cnt = exp_cnt;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/stiq_ctrl.sv
// ----------------------------------------------------------------------------
// stiq_ctrl
// Sequencer: decodes a transaction and steps the datapath through it.
// ----------------------------------------------------------------------------
module stiq_ctrl
   import stiq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_SET_INS  = 4'd2;
   localparam logic [3:0] S_REPORT   = 4'd3;
   localparam logic [3:0] S_PURGE    = 4'd4;
   localparam logic [3:0] S_TICK_CNT = 4'd5;
   localparam logic [3:0] S_FIRE     = 4'd6;
   localparam logic [3:0] S_RELOAD   = 4'd7;
   localparam logic [3:0] S_RINS     = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [FIRE_W-1:0] fire_cnt_ff, fire_cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      fire_cnt_in = fire_cnt_ff;
      cmd         = '{op: OP_NOP, sts: STS_OK, last: 1'b1};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.kind)
               KIND_SET: begin
                  if (stat.set_bad) begin
                     if (stat.out_free) begin
                        cmd.op   = OP_EMIT;
                        cmd.sts  = STS_INVAL;
                        state_in = S_IDLE;
                     end
                  end else if (stat.hit) begin
                     cmd.op   = OP_SET_REPLACE;
                     state_in = S_SET_INS;
                  end else if (stat.full) begin
                     if (stat.out_free) begin
                        cmd.op   = OP_EMIT;
                        cmd.sts  = STS_FULL;
                        state_in = S_IDLE;
                     end
                  end else begin
                     cmd.op   = OP_SET_ALLOC;
                     state_in = S_SET_INS;
                  end
               end
               KIND_GET,
               KIND_DEL: begin
                  if (stat.hit) begin
                     cmd.op   = OP_FIND;
                     state_in = S_REPORT;
                  end else if (stat.out_free) begin
                     cmd.op   = OP_EMIT;
                     cmd.sts  = STS_NOTFND;
                     state_in = S_IDLE;
                  end
               end
               KIND_PURGE: begin
                  cmd.op   = OP_PURGE_START;
                  state_in = S_PURGE;
               end
               KIND_TICK: begin
                  cmd.op   = OP_TICK_NOW;
                  state_in = S_TICK_CNT;
               end
               default: begin
                  if (stat.out_free) begin
                     cmd.op   = OP_EMIT;
                     cmd.sts  = STS_INVAL;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_SET_INS: begin
            if (stat.out_free) begin
               cmd.op   = OP_INSERT_ACK;
               state_in = S_IDLE;
            end
         end
         S_REPORT: begin
            if (stat.out_free) begin
               cmd.op   = (stat.kind == KIND_DEL) ? OP_REPORT_DEL : OP_REPORT;
               state_in = S_IDLE;
            end
         end
         // walk the queue, removing in place
         S_PURGE: begin
            if (stat.purge_end) begin
               if (stat.out_free) begin
                  cmd.op   = OP_EMIT;
                  state_in = S_IDLE;
               end
            end else if (stat.purge_hit) begin
               cmd.op = OP_REMOVE_RD;
            end else begin
               cmd.op = OP_PURGE_STEP;
            end
         end
         S_TICK_CNT: begin
            fire_cnt_in = stat.expired_cnt;
            state_in    = (stat.expired_cnt == '0) ? S_IDLE : S_FIRE;
         end
         // one expired timer per pass, head of the queue
         S_FIRE: begin
            if (stat.out_free) begin
               cmd.op      = OP_FIRE;
               cmd.last    = (fire_cnt_ff == FIRE_W'(1));
               fire_cnt_in = fire_cnt_ff - FIRE_W'(1);
               state_in    = S_RELOAD;
            end
         end
         S_RELOAD: begin
            if (stat.periodic) begin
               cmd.op   = OP_RELOAD;
               state_in = S_RINS;
            end else begin
               state_in = (fire_cnt_ff == '0) ? S_IDLE : S_FIRE;
            end
         end
         S_RINS: begin
            cmd.op   = OP_INSERT;
            state_in = (fire_cnt_ff == '0) ? S_IDLE : S_FIRE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fire_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         fire_cnt_ff <= fire_cnt_in;
      end
   end

endmodule

### hdl/sorted_interval_timer_queue_unit.sv
// Purge walks every queued timer; tick fires the expired timers one at a time from the head,
// reloading and reinserting each periodic one; a stalled result holds the sequencer.
// One transaction is worked on at a time; the next is taken once the sequencer is idle,
// while a finished result may still wait in the output register.
// Reset (synchronous) empties the queue, clears the clock and id counter and sets the registers to their defaults.
// ----------------------------------------------------------------------------
// sorted_interval_timer_queue_unit
// Multi-slot interval timer queue kept sorted by absolute expiry.
// ----------------------------------------------------------------------------
module sorted_interval_timer_queue_unit
   import stiq_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   stiq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   stiq_datapath #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_valid && req_ready),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### hdl/stiq_checker.sv
// ----------------------------------------------------------------------------
// stiq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module stiq_checker
   import stiq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one transaction in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   // error results always close their transaction
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STS_OK |-> rsp_data.last)
      else $error("error result without last");

   // a nonzero result owner only on success
   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_owner != '0 |-> rsp_data.status == STS_OK)
      else $error("fired result with error status");

endmodule

bind sorted_interval_timer_queue_unit stiq_checker u_stiq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### verif/tb_sorted_interval_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_interval_timer_queue_unit
// Self-checking bench for the sorted interval timer queue. A directed table
// covers error codes, rounding, replace and firing. Random phases with
// several register settings and idle patterns follow. Every response is
// checked against its table value or a cycle-free predictor of the queue.
// ----------------------------------------------------------------------------
module tb_sorted_interval_timer_queue_unit;
   import stiq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] KIND_BAD_LO = 3'd5;
   localparam logic [2:0] KIND_BAD_HI = 3'd7;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS  = 115;

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type x;
   } vector_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_MAX_SECONDS;
   logic [30:0] csr_wdata = '0;

   // predictor state
   entry_type   timers[$];
   time_type    clk_now;
   logic [30:0] max_sec_cfg;
   logic [19:0] res_cfg;
   logic [15:0] id_next;

   rsp_type     pending_rsp[$];
   vector_row   plan[$];
   int          errors = 0;
   int          send_idle = 0;
   int          recv_stall = 0;
   bit          hold_req = 0;
   int          hold_cnt = 0;
   bit          vld_on = 0;

   sorted_interval_timer_queue_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic bit is_after(time_type a, time_type b);
      return (a.sec > b.sec) || ((a.sec == b.sec) && (a.us > b.us));
   endfunction

   // current clock plus a relative time, seconds saturate
   function automatic time_type add_rel(logic [31:0] rs, logic [19:0] ru);
      longint   us;
      longint   s;
      time_type e;
      us = longint'(clk_now.us) + longint'(ru);
      s  = longint'(clk_now.sec) + longint'(rs);
      while (us >= 1000000) begin
         us -= 1000000;
         s++;
      end
      if (s > 64'hFFFFFFFF) begin
         s  = 64'hFFFFFFFF;
         us = 999999;
      end
      e.sec = s[31:0];
      e.us  = us[19:0];
      return e;
   endfunction

   function automatic rem_type time_left(time_type e);
      longint  s;
      longint  us;
      rem_type r;
      r = '0;
      if (is_after(e, clk_now)) begin
         s = longint'(e.sec) - longint'(clk_now.sec);
         if (e.us >= clk_now.us) begin
            us = longint'(e.us) - longint'(clk_now.us);
         end else begin
            us = longint'(e.us) + 1000000 - longint'(clk_now.us);
            s--;
         end
         if (s > 64'h7FFFFFFF) s = 64'h7FFFFFFF;
         r.sec = s[30:0];
         r.us  = us[19:0];
      end
      return r;
   endfunction

   // flags a bad time and rounds short sub-second times up to the resolution
   function automatic bit bad_time(logic [30:0] s, inout logic [19:0] us);
      logic [19:0] r;
      r = (res_cfg > 20'd999999) ? 20'd999999 : res_cfg;
      if (s > max_sec_cfg || us >= 20'd1000000) return 1'b1;
      if (s == 0 && us > 0 && us < r) us = r;
      return 1'b0;
   endfunction

   function automatic int find_timer(logic [7:0] own, logic [15:0] id);
      foreach (timers[i])
         if (timers[i].owner == own && timers[i].id == id) return i;
      return -1;
   endfunction

   function automatic void queue_timer(entry_type ent);
      int p;
      p = 0;
      if (timers.size() >= SLOTS_DEF) return;
      while (p < timers.size() && !is_after(timers[p].expiry, ent.expiry)) p++;
      timers.insert(p, ent);
   endfunction

   function automatic rsp_type short_rsp(logic [1:0] sts, logic [15:0] id);
      rsp_type x;
      x = '0;
      x.status = sts;
      x.result_id = id;
      x.last = 1'b1;
      return x;
   endfunction

   // all responses one transaction causes, with the state update
   function automatic void timer_results(req_type t, ref rsp_type outs[$]);
      logic [19:0] tu;
      logic [19:0] pu;
      logic [15:0] id;
      entry_type   ent;
      rsp_type     x;
      rem_type     rm;
      int          p;
      int          fired;
      outs.delete();
      case (t.kind)
         KIND_SET: begin
            tu = t.time_us;
            pu = t.period_us;
            if (bad_time(t.time_sec, tu) || bad_time(t.period_sec, pu)) begin
               outs.push_back(short_rsp(STS_INVAL, '0));
               return;
            end
            p = find_timer(t.owner, t.lookup_id);
            if (p >= 0) begin
               id = t.lookup_id;
               timers.delete(p);
            end else begin
               if (timers.size() >= SLOTS_DEF) begin
                  outs.push_back(short_rsp(STS_FULL, '0));
                  return;
               end
               if (id_next == 0) id_next = 16'd1;
               id = id_next;
               id_next = id_next + 16'd1;
            end
            ent = '0;
            ent.owner = t.owner;
            ent.id = id;
            ent.expiry = add_rel({1'b0, t.time_sec}, tu);
            ent.rel_sec = t.period_sec;
            ent.rel_us = pu;
            ent.ev = t.event_req;
            ent.cd = t.code;
            ent.sc = t.subcode;
            queue_timer(ent);
            outs.push_back(short_rsp(STS_OK, id));
         end
         KIND_GET, KIND_DEL: begin
            p = find_timer(t.owner, t.lookup_id);
            if (p < 0) begin
               outs.push_back(short_rsp(STS_NOTFND, '0));
               return;
            end
            rm = time_left(timers[p].expiry);
            x = short_rsp(STS_OK, '0);
            x.remain_sec = rm.sec;
            x.remain_us = rm.us;
            x.interval_sec = timers[p].rel_sec;
            x.interval_us = timers[p].rel_us;
            outs.push_back(x);
            if (t.kind == KIND_DEL) timers.delete(p);
         end
         KIND_PURGE: begin
            p = 0;
            while (p < timers.size()) begin
               if (timers[p].owner == t.owner) timers.delete(p);
               else p++;
            end
            outs.push_back(short_rsp(STS_OK, '0));
         end
         KIND_TICK: begin
            clk_now = add_rel(32'd0, t.elapsed_us);
            fired = 0;
            while (fired < timers.size() && !is_after(timers[fired].expiry, clk_now))
               fired++;
            if (fired > MAX_FIRE) fired = MAX_FIRE;
            for (int k = 0; k < fired; k++) begin
               ent = timers.pop_front();
               x = '0;
               x.result_id = ent.id;
               x.result_owner = ent.owner;
               x.fired_event = ent.ev;
               x.fired_code = ent.cd;
               x.fired_subcode = ent.sc;
               x.last = (k == fired - 1);
               outs.push_back(x);
               if (ent.rel_sec != 0 || ent.rel_us != 0) begin
                  ent.expiry = add_rel({1'b0, ent.rel_sec}, ent.rel_us);
                  queue_timer(ent);
               end
            end
         end
         default: outs.push_back(short_rsp(STS_INVAL, '0));
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic req_type mk_req(logic [2:0] kind, logic [7:0] own, logic [15:0] id,
                                      logic [30:0] ts, logic [19:0] tu, logic [30:0] ps,
                                      logic [19:0] pu, logic [31:0] ev, logic [19:0] el);
      req_type t;
      t = '0;
      t.kind = kind;
      t.owner = own;
      t.lookup_id = id;
      t.time_sec = ts;
      t.time_us = tu;
      t.period_sec = ps;
      t.period_us = pu;
      t.event_req = ev;
      t.code = ~ev;
      t.subcode = ev ^ 32'h5A5A_5A5A;
      t.elapsed_us = el;
      return t;
   endfunction

   function automatic void add_row(req_type r, bit typed, rsp_type x);
      vector_row v;
      v.r = r;
      v.typed = typed;
      v.x = x;
      plan.push_back(v);
   endfunction

   function automatic logic [30:0] rand_sec();
      int c;
      c = $urandom_range(99);
      if (c < 70) return 31'($urandom_range(3));
      if (c < 90) return 31'($urandom_range(2)) + ((max_sec_cfg > 31'd1) ? max_sec_cfg - 31'd1 : '0);
      return 31'($urandom);
   endfunction

   function automatic logic [19:0] rand_us();
      int c;
      c = $urandom_range(99);
      if (c < 75) return 20'($urandom_range(999999));
      if (c < 88) return 20'($urandom_range(2000));
      return 20'($urandom);
   endfunction

   // mostly well-formed work on live timers, some noise
   function automatic req_type gen_item();
      req_type t;
      int      c;
      int      p;
      t = '0;
      c = $urandom_range(99);
      if (c < 40) t.kind = KIND_SET;
      else if (c < 55) t.kind = KIND_GET;
      else if (c < 65) t.kind = KIND_DEL;
      else if (c < 69) t.kind = KIND_PURGE;
      else if (c < 95) t.kind = KIND_TICK;
      else t.kind = 3'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
      t.owner = ($urandom_range(9) < 8) ? 8'($urandom_range(3)) : 8'($urandom);
      t.lookup_id = 16'($urandom);
      if (timers.size() > 0 && $urandom_range(99) < 70) begin
         p = $urandom_range(timers.size() - 1);
         t.owner = timers[p].owner;
         t.lookup_id = timers[p].id;
      end
      t.time_sec = rand_sec();
      t.time_us = rand_us();
      if ($urandom_range(1)) begin
         t.period_sec = rand_sec();
         t.period_us = rand_us();
      end
      t.event_req = $urandom;
      t.code = $urandom;
      t.subcode = $urandom;
      t.elapsed_us = ($urandom_range(19) == 0) ? 20'($urandom) : 20'($urandom_range(600000));
      return t;
   endfunction

   // offer one transaction; valid stays high if the next follows at once
   task automatic offer(req_type t, bit typed, rsp_type x);
      rsp_type outs[$];
      if (!vld_on) begin
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      vld_on = 1;
      do @(posedge clock); while (!req_ready);
      timer_results(t, outs);
      if (typed) pending_rsp.push_back(x);
      else foreach (outs[i]) pending_rsp.push_back(outs[i]);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         vld_on = 0;
         @(posedge clock);
      end
   endtask

   task automatic go_idle();
      if (vld_on) begin
         req_valid <= 1'b0;
         vld_on = 0;
         @(posedge clock);
      end
      wait (pending_rsp.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [30:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_SECONDS) max_sec_cfg = val;
      else res_cfg = val[19:0];
   endtask

   // ---------------------------------------------------------------- checking
   task automatic cmp_field(string name, longint want, longint got);
      if (want != got) begin
         errors++;
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t unexpected response: expected none actual %h", $time, rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            cmp_field("status", want.status, rsp_data.status);
            cmp_field("result_id", want.result_id, rsp_data.result_id);
            cmp_field("result_owner", want.result_owner, rsp_data.result_owner);
            cmp_field("remain_sec", want.remain_sec, rsp_data.remain_sec);
            cmp_field("remain_us", want.remain_us, rsp_data.remain_us);
            cmp_field("interval_sec", want.interval_sec, rsp_data.interval_sec);
            cmp_field("interval_us", want.interval_us, rsp_data.interval_us);
            cmp_field("fired_event", want.fired_event, rsp_data.fired_event);
            cmp_field("fired_code", want.fired_code, rsp_data.fired_code);
            cmp_field("fired_subcode", want.fired_subcode, rsp_data.fired_subcode);
            cmp_field("last", want.last, rsp_data.last);
         end
      end
   end

   // receiver: long hold-off first, then random stalls
   always @(posedge clock) begin
      if (hold_req) begin
         hold_cnt = 300;
         hold_req = 0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // ---------------------------------------------------------------- main flow
   initial begin
      rsp_type x;
      int      sidle[4];
      int      rstall[4];
      sidle  = '{0, 78, 0, 16};
      rstall = '{0, 0, 78, 16};
      timers.delete();
      clk_now = '0;
      max_sec_cfg = MAXSEC_RST;
      res_cfg = RES_RST;
      id_next = '0;

      // directed table at register defaults
      add_row(mk_req(KIND_GET, 8'd0, 16'd5, 0, 0, 0, 0, 0, 0), 1, short_rsp(STS_NOTFND, '0));
      add_row(mk_req(KIND_BAD_HI, 8'hFF, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1,
              short_rsp(STS_INVAL, '0));
      add_row(mk_req(KIND_BAD_LO, 8'd0, 16'd0, 0, 0, 0, 0, 0, 0), 1, short_rsp(STS_INVAL, '0));
      add_row(mk_req(KIND_SET, 8'd1, 16'd0, 0, 20'd1000000, 0, 0, 32'd7, 0), 1,
              short_rsp(STS_INVAL, '0));
      add_row(mk_req(KIND_SET, 8'd1, 16'd0, 0, 0, 0, 20'hFFFFF, 32'd7, 0), 1,
              short_rsp(STS_INVAL, '0));
      add_row(mk_req(KIND_SET, 8'd1, 16'd0, 31'd100000001, 0, 0, 0, 32'd7, 0), 1,
              short_rsp(STS_INVAL, '0));
      add_row(mk_req(KIND_SET, 8'd1, 16'd0, 31'h7FFFFFFF, 20'hFFFFF, 31'h7FFFFFFF,
                     20'hFFFFF, 32'd7, 0), 1, short_rsp(STS_INVAL, '0));
      add_row(mk_req(KIND_SET, 8'd1, 16'd9, 0, 20'd5, 0, 0, 32'hFFFFFFFF, 0), 1,
              short_rsp(STS_OK, 16'd1));
      x = short_rsp(STS_OK, '0);
      x.remain_us = 20'd1000;
      add_row(mk_req(KIND_GET, 8'd1, 16'd1, 0, 0, 0, 0, 0, 0), 1, x);
      add_row(mk_req(KIND_SET, 8'hFF, 16'd0, 31'd100000000, 20'd999999, 31'd100000000,
                     20'd999999, 32'h80000000, 0), 1, short_rsp(STS_OK, 16'd2));
      // replace keeps the id, period rounded up
      add_row(mk_req(KIND_SET, 8'd1, 16'd1, 31'd1, 0, 0, 20'd500, 32'h7FFFFFFF, 0), 0, x);
      add_row(mk_req(KIND_GET, 8'hFF, 16'd2, 0, 0, 0, 0, 0, 0), 0, x);
      add_row(mk_req(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 20'd999999), 0, x);
      add_row(mk_req(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 20'd1), 0, x);
      // elapsed beyond one second
      add_row(mk_req(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 20'hFFFFF), 0, x);
      add_row(mk_req(KIND_DEL, 8'd1, 16'd1, 0, 0, 0, 0, 0, 0), 0, x);
      add_row(mk_req(KIND_DEL, 8'd1, 16'd1, 0, 0, 0, 0, 0, 0), 1, short_rsp(STS_NOTFND, '0));
      add_row(mk_req(KIND_PURGE, 8'hFF, 0, 0, 0, 0, 0, 0, 0), 1, short_rsp(STS_OK, '0));
      add_row(mk_req(KIND_PURGE, 8'd3, 0, 0, 0, 0, 0, 0, 0), 1, short_rsp(STS_OK, '0));
      // same expiry twice keeps insertion order
      add_row(mk_req(KIND_SET, 8'd0, 16'd0, 0, 0, 0, 0, 32'd11, 0), 0, x);
      add_row(mk_req(KIND_SET, 8'd2, 16'd0, 0, 0, 0, 0, 32'd12, 0), 0, x);
      add_row(mk_req(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 20'd0), 0, x);
      add_row(mk_req(KIND_GET, 8'd0, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1,
              short_rsp(STS_NOTFND, '0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) offer(plan[i].r, plan[i].typed, plan[i].x);
      go_idle();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_MAX_SECONDS, 31'h7FFFFFFF);
               write_reg(CSR_RESOLUTION, 31'd0);
            end
            1: begin
               write_reg(CSR_MAX_SECONDS, 31'd0);
               write_reg(CSR_RESOLUTION, 31'hFFFFF);
            end
            2: begin
               write_reg(CSR_MAX_SECONDS, 31'd50);
               write_reg(CSR_RESOLUTION, 31'd1);
            end
            default: begin
               write_reg(CSR_MAX_SECONDS, 31'd100000000);
               write_reg(CSR_RESOLUTION, 31'd999999);
            end
         endcase
         send_idle = sidle[ph];
         recv_stall = rstall[ph];
         if (ph == 0) hold_req = 1;
         for (int n = 0; n < PHASE_ITEMS; n++) offer(gen_item(), 0, x);
         go_idle();
      end

      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit
   initial begin
      #5000000;
      $display("tb: failure");
      $finish;
   end

endmodule
